[design/rmd160_pkg.sv]
package rmd160_pkg;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
	} item_t;

	typedef logic [31:0] word_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;
	localparam logic [5:0]  PAD_LIMIT = 6'd55;
	localparam int QUEUE_DEPTH = 2;

	function automatic logic [3:0] sel_left(input logic [6:0] j);
		logic [3:0] t [80];
		t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,
			4'd14,4'd15,
			4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,
			4'd11,4'd8,
			4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,
			4'd5,4'd12,
			4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,
			4'd6,4'd2,
			4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,
			4'd15,4'd13};
		return t[j];
	endfunction

	function automatic logic [3:0] sel_right(input logic [6:0] j);
		logic [3:0] t [80];
		t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,
			4'd3,4'd12,
			4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,
			4'd1,4'd2,
			4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,
			4'd4,4'd13,
			4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,
			4'd10,4'd14,
			4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,
			4'd9,4'd11};
		return t[j];
	endfunction

	function automatic logic [3:0] rot_left(input logic [6:0] j);
		logic [3:0] t [80];
		t = '{4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,
			4'd7,4'd9,4'd8,
			4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,
			4'd13,4'd12,
			4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,
			4'd7,4'd5,
			4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,
			4'd5,4'd12,
			4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,
			4'd5,4'd6};
		return t[j];
	endfunction

	function automatic logic [3:0] rot_right(input logic [6:0] j);
		logic [3:0] t [80];
		t = '{4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,
			4'd14,4'd12,4'd6,
			4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,
			4'd13,4'd11,
			4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,
			4'd7,4'd5,
			4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,
			4'd15,4'd8,
			4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,
			4'd11,4'd11};
		return t[j];
	endfunction

	function automatic logic [31:0] add_left(input logic [2:0] r);
		case (r)
			3'd0: return 32'h00000000;
			3'd1: return 32'h5A827999;
			3'd2: return 32'h6ED9EBA1;
			3'd3: return 32'h8F1BBCDC;
			default: return 32'hA953FD4E;
		endcase
	endfunction

	function automatic logic [31:0] add_right(input logic [2:0] r);
		case (r)
			3'd0: return 32'h50A28BE6;
			3'd1: return 32'h5C4DD124;
			3'd2: return 32'h6D703EF3;
			3'd3: return 32'h7A6D76E9;
			default: return 32'h00000000;
		endcase
	endfunction

	function automatic logic [31:0] mix(input logic [2:0] r, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		case (r)
			3'd0: return x ^ y ^ z;
			3'd1: return (x & y) | (~x & z);
			3'd2: return (x | ~y) ^ z;
			3'd3: return (x & z) | (y & ~z);
			default: return x ^ (y | ~z);
		endcase
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [3:0] s);
		logic [63:0] d;
		d = {x, x} << s;
		return d[63:32];
	endfunction

endpackage

[design/rmd160_stream_if.sv]
interface rmd160_stream_if #(parameter int W = 36);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[design/rmd160_front.sv]
// Accepts words into a small queue so the core can run while the source moves on.
module rmd160_front (
	input  logic                 clk,
	input  logic                 arst_n,
	rmd160_stream_if.sink        in_ch,
	output rmd160_pkg::item_t    head,
	output logic                 head_valid,
	input  logic                 head_pop
);
	rmd160_pkg::item_t slot_q [rmd160_pkg::QUEUE_DEPTH];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ch.ready = (cnt_q != 2'(rmd160_pkg::QUEUE_DEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign head = slot_q[rd_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= rmd160_pkg::item_t'(in_ch.payload);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (head_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(head_pop);
		end
	end
endmodule

[design/rmd160_core.sv]
// Gathers words, pads the last block, runs one step of both lines per cycle and sends the digest.
module rmd160_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rmd160_pkg::item_t    head,
	input  logic                 head_valid,
	output logic                 head_pop,
	rmd160_stream_if.source      out_ch
);
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_COMP = 7'b0000010,
		ST_PAD  = 7'b0000100,
		ST_LEN  = 7'b0001000,
		ST_OUT  = 7'b0010000,
		ST_PADF = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [31:0] blk_q [16];
	logic [31:0] cv_q [5];
	logic [31:0] al_q, bl_q, cl_q, dl_q, el_q, ar_q, br_q, cr_q, dr_q, er_q;
	logic [6:0] step_q;
	logic [3:0] fill_q;
	logic [63:0] len_q;
	logic [5:0] pend_q;
	logic final_q, need_len_q, extra_q;
	logic [2:0] oidx_q;
	logic [31:0] odata_q;
	logic ovalid_q, olast_q;

	logic [2:0] rd, rdr;
	logic [31:0] tl, tr, word_m;
	logic [2:0] vb;
	logic [5:0] pend;
	logic [63:0] bits;
	logic [31:0] pad_bit;
	logic [2:0] onext;

	assign rd = 3'(step_q[6:4]);
	assign rdr = 3'd4 - rd;
	assign tl = rmd160_pkg::rotl(al_q + rmd160_pkg::mix(rd, bl_q, cl_q, dl_q)
		+ blk_q[rmd160_pkg::sel_left(step_q)] + rmd160_pkg::add_left(rd),
		rmd160_pkg::rot_left(step_q)) + el_q;
	assign tr = rmd160_pkg::rotl(ar_q + rmd160_pkg::mix(rdr, br_q, cr_q, dr_q)
		+ blk_q[rmd160_pkg::sel_right(step_q)] + rmd160_pkg::add_right(rd),
		rmd160_pkg::rot_right(step_q)) + er_q;
	assign pad_bit = 32'h80 << {pend_q[1:0], 3'b000};
	assign onext = oidx_q + 3'd1;

	always_comb begin
		vb = (head.nbytes > 3'd4) ? 3'd4 : head.nbytes;
		case (vb)
			3'd0: word_m = 32'h0;
			3'd1: word_m = {24'h0, head.word[7:0]};
			3'd2: word_m = {16'h0, head.word[15:0]};
			3'd3: word_m = {8'h0, head.word[23:0]};
			default: word_m = head.word;
		endcase
		pend = {fill_q, 2'b00} + 6'(vb);
		bits = len_q << 3;
	end

	assign head_pop = (state_q == ST_IDLE) && head_valid;
	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = {odata_q, oidx_q, olast_q};

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					blk_q[fill_q] <= head.last ? word_m : head.word;
				end
				al_q <= cv_q[0]; bl_q <= cv_q[1]; cl_q <= cv_q[2];
				dl_q <= cv_q[3]; el_q <= cv_q[4];
				ar_q <= cv_q[0]; br_q <= cv_q[1]; cr_q <= cv_q[2];
				dr_q <= cv_q[3]; er_q <= cv_q[4];
			end
			ST_COMP: begin
				al_q <= el_q; el_q <= dl_q; dl_q <= rmd160_pkg::rotl(cl_q, 4'd10);
				cl_q <= bl_q; bl_q <= tl;
				ar_q <= er_q; er_q <= dr_q; dr_q <= rmd160_pkg::rotl(cr_q, 4'd10);
				cr_q <= br_q; br_q <= tr;
			end
			ST_PAD: begin
				// Bytes past the message are cleared and the pad byte lands right after the message.
				for (int k = 0; k < 16; k++) begin
					if (4'(k) == pend_q[5:2])
						blk_q[k] <= ((pend_q[1:0] == 2'd0) ? 32'h0 : blk_q[k]) | pad_bit;
					else if (4'(k) > pend_q[5:2])
						blk_q[k] <= 32'h0;
				end
			end
			ST_FIN: begin
				al_q <= cv_q[0]; bl_q <= cv_q[1]; cl_q <= cv_q[2];
				dl_q <= cv_q[3]; el_q <= cv_q[4];
				ar_q <= cv_q[0]; br_q <= cv_q[1]; cr_q <= cv_q[2];
				dr_q <= cv_q[3]; er_q <= cv_q[4];
			end
			ST_PADF: begin
				for (int k = 0; k < 16; k++) blk_q[k] <= 32'h0;
			end
			ST_LEN: begin
				blk_q[14] <= bits[31:0];
				blk_q[15] <= bits[63:32];
				al_q <= cv_q[0]; bl_q <= cv_q[1]; cl_q <= cv_q[2];
				dl_q <= cv_q[3]; el_q <= cv_q[4];
				ar_q <= cv_q[0]; br_q <= cv_q[1]; cr_q <= cv_q[2];
				dr_q <= cv_q[3]; er_q <= cv_q[4];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q <= '{rmd160_pkg::IV0, rmd160_pkg::IV1, rmd160_pkg::IV2,
				rmd160_pkg::IV3, rmd160_pkg::IV4};
			step_q <= 7'd0;
			fill_q <= 4'd0;
			len_q <= 64'd0;
			pend_q <= 6'd0;
			final_q <= 1'b0;
			need_len_q <= 1'b0;
			extra_q <= 1'b0;
			oidx_q <= 3'd0;
			odata_q <= 32'h0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						step_q <= 7'd0;
						if (!head.last) begin
							len_q <= len_q + 64'd4;
							fill_q <= fill_q + 4'd1;
							final_q <= 1'b0;
							if (fill_q == 4'd15) state_q <= ST_COMP;
						end else begin
							len_q <= len_q + 64'(vb);
							final_q <= 1'b1;
							if (pend == 6'd0 && fill_q == 4'd15 && vb == 3'd4) begin
								pend_q <= 6'd0;
								state_q <= ST_COMP;
							end else begin
								pend_q <= pend;
								state_q <= ST_PAD;
							end
							fill_q <= 4'd0;
						end
					end
				end
				ST_COMP: begin
					step_q <= step_q + 7'd1;
					if (step_q == 7'd79) begin
						cv_q[0] <= cv_q[1] + bl_q + rmd160_pkg::rotl(cr_q, 4'd10);
						cv_q[1] <= cv_q[2] + rmd160_pkg::rotl(cl_q, 4'd10) + dr_q;
						cv_q[2] <= cv_q[3] + dl_q + er_q;
						cv_q[3] <= cv_q[4] + el_q + tr;
						cv_q[4] <= cv_q[0] + tl + br_q;
						if (!final_q) state_q <= ST_IDLE;
						else if (need_len_q) state_q <= ST_OUT;
						else if (extra_q) state_q <= ST_PADF;
						else state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (pend_q > rmd160_pkg::PAD_LIMIT) state_q <= ST_FIN;
					else state_q <= ST_LEN;
				end
				ST_FIN: begin
					// Compress the padded block, then start the length block.
					step_q <= 7'd0;
					need_len_q <= 1'b0;
					extra_q <= 1'b1;
					state_q <= ST_COMP;
				end
				ST_PADF: begin
					extra_q <= 1'b0;
					state_q <= ST_LEN;
				end
				ST_LEN: begin
					step_q <= 7'd0;
					need_len_q <= 1'b1;
					oidx_q <= 3'd0;
					state_q <= ST_COMP;
				end
				ST_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						odata_q <= cv_q[0];
						oidx_q <= 3'd0;
						olast_q <= 1'b0;
					end else if (out_ch.ready) begin
						if (olast_q) begin
							ovalid_q <= 1'b0;
							olast_q <= 1'b0;
							oidx_q <= 3'd0;
							need_len_q <= 1'b0;
							final_q <= 1'b0;
							len_q <= 64'd0;
							cv_q <= '{rmd160_pkg::IV0, rmd160_pkg::IV1, rmd160_pkg::IV2,
								rmd160_pkg::IV3, rmd160_pkg::IV4};
							state_q <= ST_IDLE;
						end else begin
							odata_q <= cv_q[onext];
							oidx_q <= onext;
							olast_q <= (oidx_q == 3'd3);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/ripemd160_hash_engine.sv]
// RIPEMD-160 engine: a non-final word is stored, and every sixteenth word starts
// a compression, both lines stepping once per cycle in two parallel round datapaths;
// a final word adds padding, one or two compressions and five output transactions.
module ripemd160_hash_engine (
	input  logic            clk,
	input  logic            arst_n,
	rmd160_stream_if.sink   in_ch,
	rmd160_stream_if.source out_ch
);
	rmd160_pkg::item_t head;
	logic head_valid, head_pop;

	rmd160_front u_front (
		.clk, .arst_n, .in_ch, .head, .head_valid, .head_pop
	);
	rmd160_core u_core (
		.clk, .arst_n, .head, .head_valid, .head_pop, .out_ch
	);
endmodule

[design/rmd160_checker.sv]
module rmd160_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [35:0] out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("output dropped while stalled");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_payload[0] == (out_payload[3:1] == 3'd4)))
		else $error("last flag disagrees with index");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload[3:1] <= 3'd4)
		else $error("index out of range");
endmodule

bind ripemd160_hash_engine rmd160_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_payload(out_ch.payload)
);

[sim/tb_ripemd160_hash_engine.sv]
`timescale 1ns / 100ps

module tb_ripemd160_hash_engine;
	typedef rmd160_pkg::word_t word_t;
	typedef rmd160_pkg::item_t item_t;

	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_exp_t;

	localparam int LSEL [80] = '{
		0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,
		7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
		3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12,
		1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
		4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
	localparam int RSEL [80] = '{
		5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12,
		6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
		15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13,
		8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
		12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
	localparam int LROT [80] = '{
		11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8,
		7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
		11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5,
		11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
		9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
	localparam int RROT [80] = '{
		8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6,
		9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
		9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5,
		15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
		8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
	localparam word_t LADD [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
		32'h8F1BBCDC, 32'hA953FD4E};
	localparam word_t RADD [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
		32'h7A6D76E9, 32'h00000000};

	logic clk;
	logic arst_n;

	rmd160_stream_if in_ch();
	rmd160_stream_if out_ch();

	ripemd160_hash_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Predictor state for the message being hashed.
	word_t       chain [5];
	word_t       block_buf [16];
	int          fill;
	logic [63:0] msg_bytes;

	digest_exp_t digest_q [$];
	int          errors;
	int          words_sent;
	int          messages_sent;
	int          digests_seen;
	int          cycles;
	int          hold_off;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic word_t rol(input word_t x, input int s);
		return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
	endfunction

	function automatic word_t round_fn(input int r, input word_t x, input word_t y,
		input word_t z);
		case (r)
			0: return x ^ y ^ z;
			1: return (x & y) | (~x & z);
			2: return (x | ~y) ^ z;
			3: return (x & z) | (y & ~z);
			default: return x ^ (y | ~z);
		endcase
	endfunction

	function automatic void clear_hash();
		chain = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
		foreach (block_buf[i]) block_buf[i] = '0;
		fill = 0;
		msg_bytes = '0;
	endfunction

	function automatic void compress_block();
		word_t al, bl, cl, dl, el, ar, br, cr, dr, er, t, h1;
		int r;
		al = chain[0]; bl = chain[1]; cl = chain[2]; dl = chain[3]; el = chain[4];
		ar = al; br = bl; cr = cl; dr = dl; er = el;
		for (int j = 0; j < 80; j++) begin
			r = j / 16;
			t = rol(al + round_fn(r, bl, cl, dl) + block_buf[LSEL[j]] + LADD[r], LROT[j]) + el;
			al = el; el = dl; dl = rol(cl, 10); cl = bl; bl = t;
			t = rol(ar + round_fn(4 - r, br, cr, dr) + block_buf[RSEL[j]] + RADD[r],
				RROT[j]) + er;
			ar = er; er = dr; dr = rol(cr, 10); cr = br; br = t;
		end
		h1 = chain[1] + cl + dr;
		chain[1] = chain[2] + dl + er;
		chain[2] = chain[3] + el + ar;
		chain[3] = chain[4] + al + br;
		chain[4] = chain[0] + bl + cr;
		chain[0] = h1;
	endfunction

	// Absorb one accepted word; a final word pads, finishes and queues the digest.
	function automatic void absorb_word(input item_t it);
		int nb, pend;
		word_t w;
		logic [63:0] bits;
		digest_exp_t d;
		w = it.word;
		if (!it.last) begin
			block_buf[fill] = w;
			msg_bytes += 4;
			fill++;
			if (fill == 16) begin
				compress_block();
				fill = 0;
			end
			return;
		end
		nb = (it.nbytes > 4) ? 4 : int'(it.nbytes);
		if (nb < 4) w &= (32'h1 << (8 * nb)) - 1;
		block_buf[fill] = w;
		msg_bytes += nb;
		pend = fill * 4 + nb;
		if (pend == 64) begin
			compress_block();
			pend = 0;
		end
		for (int k = (pend + 3) / 4; k < 16; k++) block_buf[k] = '0;
		block_buf[pend / 4] ^= 32'h1 << (8 * (pend % 4) + 7);
		if (pend > 55) begin
			compress_block();
			foreach (block_buf[i]) block_buf[i] = '0;
		end
		bits = msg_bytes << 3;
		block_buf[14] = bits[31:0];
		block_buf[15] = bits[63:32];
		compress_block();
		for (int k = 0; k < 5; k++) begin
			d.word = chain[k];
			d.index = 3'(k);
			d.last = (k == 4);
			digest_q.push_back(d);
		end
		clear_hash();
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 65) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		$display("ERROR %0t: digest %s expected %h got %h", $realtime, what, want, got);
		errors++;
	endtask

	task automatic send_word(input word_t w, input logic [2:0] nb, input logic last);
		item_t it;
		int gap;
		it.word = w;
		it.nbytes = nb;
		it.last = last;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		absorb_word(it);
		words_sent++;
		if (last) messages_sent++;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Message of len bytes with random content; the final word may carry all four.
	task automatic send_message(input int len, input bit full_tail);
		int whole, tail;
		whole = len / 4;
		tail = len % 4;
		if (full_tail && tail == 0 && whole > 0) begin
			whole--;
			tail = 4;
		end
		for (int i = 0; i < whole; i++) send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom, 3'(tail), 1'b1);
	endtask

	task automatic wait_idle();
		stop_sending();
		wait (digest_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_edge_messages();
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'h00636261, 3'd3, 1'b1);
		send_word(32'hFFFFFFFF, 3'd4, 1'b1);
		send_word(32'hFFFFFFFF, 3'd5, 1'b1);
		send_word(32'hA5A5A5A5, 3'd6, 1'b1);
		send_word(32'h5A5A5A5A, 3'd7, 1'b1);
		send_word(32'hFFFFFFFF, 3'd1, 1'b1);
		send_word(32'hFFFFFFFF, 3'd2, 1'b1);
	endtask

	task automatic test_padding_boundaries();
		send_message(55, 1'b0);
		send_message(56, 1'b1);
		send_message(63, 1'b0);
		// Last word fills the block, so padding starts a new one.
		send_message(64, 1'b1);
		send_message(64, 1'b0);
		wait_idle();
	endtask

	task automatic test_backpressure();
		hold_off = 400;
		send_message(140, 1'b1);
		send_message(9, 1'b0);
		wait_idle();
	endtask

	task automatic test_random_messages();
		int len;
		while (words_sent < 330) begin
			no_idle = ($urandom_range(0, 5) == 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 300) :
				$urandom_range(0, 130);
			send_message(len, $urandom_range(0, 1));
			if ($urandom_range(0, 7) == 0) wait_idle();
		end
		no_idle = 1'b0;
		wait_idle();
	endtask

	always @(negedge clk) begin : ready_drive
		static int stall = 0;
		int r;
		if (hold_off > 0) begin
			hold_off--;
			out_ch.ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			out_ch.ready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (no_idle || r < 70) begin
				out_ch.ready <= 1'b1;
			end else begin
				stall = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				out_ch.ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : digest_check
		digest_exp_t d;
		word_t dw;
		logic [2:0] idx;
		logic dl;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			{dw, idx, dl} = out_ch.payload;
			if (digest_q.size() == 0) begin
				report_mismatch("unexpected transaction", '0, dw);
			end else begin
				d = digest_q.pop_front();
				if (dw !== d.word) report_mismatch("word", d.word, dw);
				if (idx !== d.index) report_mismatch("index", 32'(d.index), 32'(idx));
				if (dl !== d.last) report_mismatch("last flag", 32'(d.last), 32'(dl));
				if (d.last) digests_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		errors = 0;
		words_sent = 0;
		messages_sent = 0;
		digests_seen = 0;
		cycles = 0;
		hold_off = 0;
		no_idle = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		clear_hash();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_edge_messages();
		test_padding_boundaries();
		test_backpressure();
		test_random_messages();
		$display("Hashed %0d messages from %0d words, checked %0d digests.",
			messages_sent, words_sent, digests_seen);
		$display("Covered empty and partial tails, padding boundaries and long output stalls.");
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
